// File: rtl/core/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg: bellows stroke sequencer shared definitions
// Widths, reset values, request, mode and register codes, sequencer states.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int unsigned SAMPLE_BITS_DEF = 8;

   localparam int unsigned REQ_W      = 2;
   localparam int unsigned SMP_W      = 8;
   localparam int unsigned HOME_W     = 12;
   localparam int unsigned GEAR_W     = 4;
   localparam int unsigned RMAX_W     = 8;
   localparam int unsigned LIMIT_W    = 8;
   localparam int unsigned PAUSE_W    = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned PERIOD_W   = 32;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // shared multiplier: accumulator times one narrow operand
   localparam int unsigned MULA_W = 32;
   localparam int unsigned MULB_W = 12;
   localparam int unsigned PROD_W = MULA_W + MULB_W;
   // vol * home * gear * rate * rate_max: 8 + 12 + 4 + 8 + 8
   localparam int unsigned DEN_W  = 40;

   // numerator = CLOCK_HZ * SEC_PER_MIN << 2*SAMPLE_BITS; the product needs 30 bits
   localparam logic [63:0] CLOCK_HZ    = 64'd16000000;
   localparam logic [63:0] SEC_PER_MIN = 64'd60;
   localparam int unsigned NUM_BASE_W  = 30;

   localparam logic [PERIOD_W-1:0] MIN_PERIOD = 32'd100;

   localparam logic [HOME_W-1:0]  HOME_STEPS_RST     = 12'd1620;
   localparam logic [GEAR_W-1:0]  GEAR_FACTOR_RST    = 4'd4;
   localparam logic [RMAX_W-1:0]  RATE_MAX_RST       = 8'd100;
   localparam logic [LIMIT_W-1:0] PRESSURE_LIMIT_RST = 8'd200;
   localparam logic [PAUSE_W-1:0] UP_PAUSE_RST       = 16'd180;
   localparam logic [PAUSE_W-1:0] DOWN_PAUSE_RST     = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_HOME_STEPS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_FACTOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_MAX       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_PAUSE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_PAUSE     = 3'd5;

   typedef enum logic [REQ_W-1:0] {
      REQ_STEP    = 2'd0,
      REQ_HOME    = 2'd1,
      REQ_BREATHE = 2'd2
   } req_code_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE    = 2'd0,
      MODE_HOME    = 2'd1,
      MODE_BREATHE = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC,
      ST_TOT,
      ST_TGT,
      ST_VOL,
      ST_RATE,
      ST_RMAX,
      ST_DIVGO,
      ST_DIVW,
      ST_STROKE,
      ST_OUT
   } fsm_state_type;

endpackage

// File: rtl/core/bss_div.sv
// ----------------------------------------------------------------------------
// bss_div: radix-2 restoring divider
// Divides a fixed numerator by a registered divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bss_div #(
   parameter int unsigned NUM_W = 46,
   parameter int unsigned DEN_W = 40,
   parameter logic [NUM_W-1:0] NUM = '0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // shift next numerator bit into the partial remainder
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         den_in  = den;
         rem_in  = '0;
         quo_in  = NUM;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: rtl/core/bellows_stroke_sequencer_unit.sv
// ----------------------------------------------------------------------------
// bellows_stroke_sequencer_unit: stepper bellows stroke sequencer
// Homing and breathing control with stroke timing from an iterative divider.
// ----------------------------------------------------------------------------
// Steps: a homing start, a plain step pulse or an idle pulse pass the
//   decode and output states; a breathing start adds the total and target
//   products; a stroke end adds those, the volume, rate and rate-max
//   products and, for a nonzero divisor, the divider (one quotient bit per cycle).
// Throughput: one item at a time; the next transfer is taken the cycle after
//   the result is registered, even while that result still waits downstream.
// Reset: synchronous, active high; registers back to their defaults, idle.
// ----------------------------------------------------------------------------
module bellows_stroke_sequencer_unit #(
   parameter int unsigned SAMPLE_BITS = bss_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bss_pkg::REQ_W-1:0]         req_type,
   input  logic [bss_pkg::SMP_W-1:0]         req_volume_pot,
   input  logic [bss_pkg::SMP_W-1:0]         req_rate_pot,
   input  logic [bss_pkg::SMP_W-1:0]         req_bellows_pressure,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_update_valid,
   output logic                              rsp_direction_up,
   output logic [bss_pkg::PERIOD_W-1:0]      rsp_step_period,
   output logic [bss_pkg::PERIOD_W-1:0]      rsp_step_compare,
   output logic [bss_pkg::PAUSE_W-1:0]       rsp_pause_ms,
   output logic                              rsp_motor_enable,
   output logic                              rsp_pressure_alarm,
   output logic [bss_pkg::MODE_W-1:0]        rsp_mode,
   // register write port
   input  logic                              csr_write_en,
   input  logic [bss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned COUNT_W  = bss_pkg::COUNT_W;
   localparam int unsigned PERIOD_W = bss_pkg::PERIOD_W;
   localparam int unsigned DEN_W    = bss_pkg::DEN_W;
   localparam int unsigned PROD_W   = bss_pkg::PROD_W;
   localparam int unsigned MULA_W   = bss_pkg::MULA_W;
   localparam int unsigned MULB_W   = bss_pkg::MULB_W;
   // numerator: ticks per minute scaled by the two pot full-scales
   localparam int unsigned NUM_W    = bss_pkg::NUM_BASE_W + 2 * SAMPLE_BITS;
   localparam logic [NUM_W-1:0] DIV_NUM =
      NUM_W'(bss_pkg::CLOCK_HZ * bss_pkg::SEC_PER_MIN) << (2 * SAMPLE_BITS);

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   bss_pkg::fsm_state_type state_ff, state_in;

   // configuration
   logic [bss_pkg::HOME_W-1:0]  home_ff, home_in;
   logic [bss_pkg::GEAR_W-1:0]  gear_ff, gear_in;
   logic [bss_pkg::RMAX_W-1:0]  rmax_ff, rmax_in;
   logic [bss_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [bss_pkg::PAUSE_W-1:0] up_pause_ff, up_pause_in;
   logic [bss_pkg::PAUSE_W-1:0] down_pause_ff, down_pause_in;

   // sequencer state kept between items
   bss_pkg::mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [COUNT_W-1:0]          target_ff, target_in;
   logic                        next_up_ff, next_up_in;
   logic                        motor_ff, motor_in;
   logic                        alarm_ff, alarm_in;
   logic [PERIOD_W-1:0]         lp_ff, lp_in;

   // captured request
   logic [bss_pkg::REQ_W-1:0]   rtype_ff, rtype_in;
   logic [bss_pkg::SMP_W-1:0]   vol_ff, vol_in;
   logic [bss_pkg::SMP_W-1:0]   rate_ff, rate_in;
   logic [bss_pkg::SMP_W-1:0]   pres_ff, pres_in;

   // working values
   logic [DEN_W-1:0]            acc_ff, acc_in;      // total steps, then divisor
   logic [COUNT_W-1:0]          tgt_ff, tgt_in;      // next up-stroke target
   logic                        stroke_ff, stroke_in; // item ends a stroke
   logic                        upd_ff, upd_in;
   logic [PERIOD_W-1:0]         per_ff, per_in;
   logic [PERIOD_W-1:0]         cmp_ff, cmp_in;
   logic [bss_pkg::PAUSE_W-1:0] pause_ff, pause_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        o_upd_ff, o_upd_in;
   logic                        o_dir_ff, o_dir_in;
   logic [PERIOD_W-1:0]         o_per_ff, o_per_in;
   logic [PERIOD_W-1:0]         o_cmp_ff, o_cmp_in;
   logic [bss_pkg::PAUSE_W-1:0] o_pause_ff, o_pause_in;
   logic                        o_motor_ff, o_motor_in;
   logic                        o_alarm_ff, o_alarm_in;
   logic [bss_pkg::MODE_W-1:0]  o_mode_ff, o_mode_in;

   // ---------------------------------------------------------------------
   // shared multiplier: one product per cycle, always registered after
   // ---------------------------------------------------------------------
   logic [MULA_W-1:0] mul_a;
   logic [MULB_W-1:0] mul_b;
   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // stroke base: (home*gear - home/2) >> SAMPLE_BITS, zero on a short gear
   logic [COUNT_W-1:0] total;
   logic [COUNT_W-1:0] half;
   logic [COUNT_W-1:0] base;

   assign total = acc_ff[COUNT_W-1:0];
   assign half  = COUNT_W'(home_ff >> 1);
   assign base  = (total >= half) ? ((total - half) >> SAMPLE_BITS) : '0;

   // ---------------------------------------------------------------------
   // divider and period saturation
   // ---------------------------------------------------------------------
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;
   logic [NUM_W-1:0] quot_m1;
   logic [PERIOD_W-1:0] period_sat;

   bss_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .NUM   (DIV_NUM)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (acc_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign quot_m1 = div_quot - NUM_W'(1);

   always_comb begin
      if (div_quot <= NUM_W'(1)) begin
         period_sat = bss_pkg::MIN_PERIOD;       // period below one tick
      end else if (|quot_m1[NUM_W-1:PERIOD_W]) begin
         period_sat = '1;                        // too long for the timer
      end else begin
         period_sat = quot_m1[PERIOD_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != bss_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      home_in       = home_ff;
      gear_in       = gear_ff;
      rmax_in       = rmax_ff;
      limit_in      = limit_ff;
      up_pause_in   = up_pause_ff;
      down_pause_in = down_pause_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      next_up_in    = next_up_ff;
      motor_in      = motor_ff;
      alarm_in      = alarm_ff;
      lp_in         = lp_ff;
      rtype_in      = rtype_ff;
      vol_in        = vol_ff;
      rate_in       = rate_ff;
      pres_in       = pres_ff;
      acc_in        = acc_ff;
      tgt_in        = tgt_ff;
      stroke_in     = stroke_ff;
      upd_in        = upd_ff;
      per_in        = per_ff;
      cmp_in        = cmp_ff;
      pause_in      = pause_ff;
      rsp_valid_in  = rsp_valid_ff;
      o_upd_in      = o_upd_ff;
      o_dir_in      = o_dir_ff;
      o_per_in      = o_per_ff;
      o_cmp_in      = o_cmp_ff;
      o_pause_in    = o_pause_ff;
      o_motor_in    = o_motor_ff;
      o_alarm_in    = o_alarm_ff;
      o_mode_in     = o_mode_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;

      // config writes must come only while idle; the block does not enforce it
      if (csr_write_en) begin
         case (csr_index)
            bss_pkg::CSR_HOME_STEPS:     home_in       = csr_wdata[bss_pkg::HOME_W-1:0];
            bss_pkg::CSR_GEAR_FACTOR:    gear_in       = csr_wdata[bss_pkg::GEAR_W-1:0];
            bss_pkg::CSR_RATE_MAX:       rmax_in       = csr_wdata[bss_pkg::RMAX_W-1:0];
            bss_pkg::CSR_PRESSURE_LIMIT: limit_in      = csr_wdata[bss_pkg::LIMIT_W-1:0];
            bss_pkg::CSR_UP_PAUSE:       up_pause_in   = csr_wdata[bss_pkg::PAUSE_W-1:0];
            bss_pkg::CSR_DOWN_PAUSE:     down_pause_in = csr_wdata[bss_pkg::PAUSE_W-1:0];
            default: ;
         endcase
      end

      // result leaves on its transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (req_valid) begin
               rtype_in = req_type;
               vol_in   = req_volume_pot;
               rate_in  = req_rate_pot;
               pres_in  = req_bellows_pressure;
               state_in = bss_pkg::ST_DEC;
            end
         end

         bss_pkg::ST_DEC: begin
            upd_in    = 1'b0;
            per_in    = '0;
            cmp_in    = '0;
            pause_in  = '0;
            stroke_in = 1'b0;
            state_in  = bss_pkg::ST_OUT;
            case (rtype_ff)
               bss_pkg::REQ_HOME: begin
                  count_in   = '0;
                  target_in  = '0;
                  next_up_in = 1'b0;
                  alarm_in   = 1'b0;
                  mode_in    = bss_pkg::MODE_HOME;
                  motor_in   = 1'b1;
               end
               bss_pkg::REQ_BREATHE: begin
                  state_in = bss_pkg::ST_TOT;
               end
               bss_pkg::REQ_STEP: begin
                  case (mode_ff)
                     bss_pkg::MODE_HOME: begin
                        next_up_in = 1'b0;
                        target_in  = COUNT_W'(home_ff);
                        if (count_ff >= COUNT_W'(home_ff)) begin
                           count_in = '0;
                           mode_in  = bss_pkg::MODE_IDLE;
                           motor_in = 1'b0;
                        end else begin
                           count_in = count_ff + COUNT_W'(1);
                        end
                     end
                     bss_pkg::MODE_BREATHE: begin
                        alarm_in = (pres_ff > limit_ff);
                        if (count_ff >= target_ff) begin
                           count_in  = '0;
                           stroke_in = 1'b1;
                           state_in  = bss_pkg::ST_TOT;
                        end else begin
                           count_in = count_ff + COUNT_W'(1);
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;   // unused request code
            endcase
         end

         bss_pkg::ST_TOT: begin
            mul_a    = MULA_W'(gear_ff);
            mul_b    = MULB_W'(home_ff);
            acc_in   = prod[DEN_W-1:0];
            state_in = bss_pkg::ST_TGT;
         end

         bss_pkg::ST_TGT: begin
            mul_a  = MULA_W'(base);
            mul_b  = MULB_W'(vol_ff);
            tgt_in = prod[COUNT_W-1:0];
            if (stroke_ff) begin
               state_in = bss_pkg::ST_VOL;
            end else begin
               target_in = prod[COUNT_W-1:0];
               mode_in   = bss_pkg::MODE_BREATHE;
               motor_in  = 1'b1;
               state_in  = bss_pkg::ST_OUT;
            end
         end

         bss_pkg::ST_VOL: begin
            mul_a    = acc_ff[MULA_W-1:0];
            mul_b    = MULB_W'(vol_ff);
            acc_in   = prod[DEN_W-1:0];
            state_in = bss_pkg::ST_RATE;
         end

         bss_pkg::ST_RATE: begin
            mul_a    = acc_ff[MULA_W-1:0];
            mul_b    = MULB_W'(rate_ff);
            acc_in   = prod[DEN_W-1:0];
            state_in = bss_pkg::ST_RMAX;
         end

         bss_pkg::ST_RMAX: begin
            mul_a    = acc_ff[MULA_W-1:0];
            mul_b    = MULB_W'(rmax_ff);
            acc_in   = prod[DEN_W-1:0];
            state_in = bss_pkg::ST_DIVGO;
         end

         bss_pkg::ST_DIVGO: begin
            if (acc_ff == '0) begin
               lp_in    = '1;      // zero divisor saturates
               state_in = bss_pkg::ST_STROKE;
            end else begin
               div_start = 1'b1;
               state_in  = bss_pkg::ST_DIVW;
            end
         end

         bss_pkg::ST_DIVW: begin
            if (div_done) begin
               lp_in    = period_sat;
               state_in = bss_pkg::ST_STROKE;
            end
         end

         bss_pkg::ST_STROKE: begin
            upd_in = 1'b1;
            if (next_up_ff) begin
               // up stroke ends: full period, fresh target
               next_up_in = 1'b0;
               target_in  = tgt_ff;
               per_in     = lp_ff;
               cmp_in     = lp_ff >> 1;
               pause_in   = up_pause_ff;
            end else begin
               // down stroke ends: half period
               next_up_in = 1'b1;
               per_in     = lp_ff >> 1;
               cmp_in     = lp_ff >> 2;
               pause_in   = down_pause_ff;
            end
            state_in = bss_pkg::ST_OUT;
         end

         bss_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_upd_in     = upd_ff;
               o_dir_in     = !next_up_ff;
               o_per_in     = per_ff;
               o_cmp_in     = cmp_ff;
               o_pause_in   = pause_ff;
               o_motor_in   = motor_ff;
               o_alarm_in   = alarm_ff;
               o_mode_in    = mode_ff;
               state_in     = bss_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bss_pkg::ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bss_pkg::ST_IDLE;
         home_ff       <= bss_pkg::HOME_STEPS_RST;
         gear_ff       <= bss_pkg::GEAR_FACTOR_RST;
         rmax_ff       <= bss_pkg::RATE_MAX_RST;
         limit_ff      <= bss_pkg::PRESSURE_LIMIT_RST;
         up_pause_ff   <= bss_pkg::UP_PAUSE_RST;
         down_pause_ff <= bss_pkg::DOWN_PAUSE_RST;
         mode_ff       <= bss_pkg::MODE_IDLE;
         count_ff      <= '0;
         target_ff     <= '0;
         next_up_ff    <= 1'b0;
         motor_ff      <= 1'b0;
         alarm_ff      <= 1'b0;
         lp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         home_ff       <= home_in;
         gear_ff       <= gear_in;
         rmax_ff       <= rmax_in;
         limit_ff      <= limit_in;
         up_pause_ff   <= up_pause_in;
         down_pause_ff <= down_pause_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         target_ff     <= target_in;
         next_up_ff    <= next_up_in;
         motor_ff      <= motor_in;
         alarm_ff      <= alarm_in;
         lp_ff         <= lp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rtype_ff   <= rtype_in;
      vol_ff     <= vol_in;
      rate_ff    <= rate_in;
      pres_ff    <= pres_in;
      acc_ff     <= acc_in;
      tgt_ff     <= tgt_in;
      stroke_ff  <= stroke_in;
      upd_ff     <= upd_in;
      per_ff     <= per_in;
      cmp_ff     <= cmp_in;
      pause_ff   <= pause_in;
      o_upd_ff   <= o_upd_in;
      o_dir_ff   <= o_dir_in;
      o_per_ff   <= o_per_in;
      o_cmp_ff   <= o_cmp_in;
      o_pause_ff <= o_pause_in;
      o_motor_ff <= o_motor_in;
      o_alarm_ff <= o_alarm_in;
      o_mode_ff  <= o_mode_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_update_valid   = o_upd_ff;
   assign rsp_direction_up   = o_dir_ff;
   assign rsp_step_period    = o_per_ff;
   assign rsp_step_compare   = o_cmp_ff;
   assign rsp_pause_ms       = o_pause_ff;
   assign rsp_motor_enable   = o_motor_ff;
   assign rsp_pressure_alarm = o_alarm_ff;
   assign rsp_mode           = o_mode_ff;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for bellows_stroke_sequencer_unit
// Drives homing and breathing sessions, step pulses and noise requests with
// random sender bursts and receiver stalls. Every result is checked field by
// field against a fixed directed value or a cycle-free predictor of the
// sequencer, over several register settings, both range extremes among them.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bss_pkg::*;

   localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;

   // request code the block must ignore (still answers with its state)
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // stroke timing constants, kept local to the predictor
   localparam longint unsigned TICKS_PER_SEC = 64'd16_000_000;
   localparam longint unsigned SEC_PER_MINUTE = 64'd60;
   localparam logic [31:0] PERIOD_FLOOR = 32'd100;
   localparam logic [31:0] PERIOD_SAT = 32'hFFFF_FFFF;

   localparam int ITEMS_PER_SETTING = 210;
   localparam int NUM_SETTINGS = 6;
   localparam int DRAIN_CYCLES = 64;    // longest item is a stroke end
   localparam int N_DIRECTED = 21;

   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [SMP_W-1:0] volume;
      logic [SMP_W-1:0] rate;
      logic [SMP_W-1:0] pressure;
   } bellows_req_type;

   typedef struct packed {
      logic              update;
      logic              dir_up;
      logic [31:0]       period;
      logic [31:0]       compare;
      logic [15:0]       pause;
      logic              motor;
      logic              alarm;
      logic [MODE_W-1:0] mode;
   } stroke_update_type;

   typedef struct packed {
      bellows_req_type   req;
      logic              typed;   // 1: result below is fixed, else predicted
      stroke_update_type want;
   } directed_row_type;

   typedef struct packed {
      logic [HOME_W-1:0]  home;
      logic [GEAR_W-1:0]  gear;
      logic [RMAX_W-1:0]  rmax;
      logic [LIMIT_W-1:0] limit;
      logic [PAUSE_W-1:0] up_pause;
      logic [PAUSE_W-1:0] down_pause;
   } cfg_setting_type;

   // quiet results: no stroke end, state only
   localparam stroke_update_type QUIET_IDLE =
      '{1'b0, 1'b1, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, MODE_IDLE};
   localparam stroke_update_type QUIET_HOMING =
      '{1'b0, 1'b1, 32'd0, 32'd0, 16'd0, 1'b1, 1'b0, MODE_HOME};
   localparam stroke_update_type QUIET_BREATHING =
      '{1'b0, 1'b1, 32'd0, 32'd0, 16'd0, 1'b1, 1'b0, MODE_BREATHE};

   // Directed run at reset defaults (home 1620, gear 4, rate max 100,
   // limit 200, pauses 180 / 100). A breathing start with zero volume gives
   // a zero target, so every pulse then ends a stroke.
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // pulse and unused code while idle: no change
      '{'{REQ_STEP,    8'd255, 8'd255, 8'd255}, 1'b1, QUIET_IDLE},
      '{'{REQ_UNUSED,  8'd0,   8'd0,   8'd0},   1'b1, QUIET_IDLE},
      // homing start, one homing pulse, unused code while homing
      '{'{REQ_HOME,    8'd0,   8'd0,   8'd0},   1'b1, QUIET_HOMING},
      '{'{REQ_STEP,    8'd255, 8'd255, 8'd255}, 1'b1, QUIET_HOMING},
      '{'{REQ_UNUSED,  8'd255, 8'd255, 8'd255}, 1'b1, QUIET_HOMING},
      // breathing with zero target, count kept from homing
      '{'{REQ_BREATHE, 8'd0,   8'd170, 8'd85},  1'b1, QUIET_BREATHING},
      // zero volume: zero divisor, down stroke, pressure just over limit
      '{'{REQ_STEP,    8'd0,   8'd0,   8'd201}, 1'b1,
        '{1'b1, 1'b0, 32'h7FFF_FFFF, 32'h3FFF_FFFF, 16'd100, 1'b1, 1'b1,
          MODE_BREATHE}},
      // zero volume again: up stroke, pressure at limit clears alarm
      '{'{REQ_STEP,    8'd0,   8'd255, 8'd200}, 1'b1,
        '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd180, 1'b1, 1'b0,
          MODE_BREATHE}},
      // zero rate: zero divisor, down stroke
      '{'{REQ_STEP,    8'd255, 8'd0,   8'd0},   1'b1,
        '{1'b1, 1'b0, 32'h7FFF_FFFF, 32'h3FFF_FFFF, 16'd100, 1'b1, 1'b0,
          MODE_BREATHE}},
      // full scale pots: shortest period at defaults, long target after
      '{'{REQ_STEP,    8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{'{REQ_STEP,    8'd128, 8'd128, 8'd0},   1'b0, '0},
      '{'{REQ_BREATHE, 8'd1,   8'd85,  8'd170}, 1'b0, '0},
      '{'{REQ_STEP,    8'd1,   8'd1,   8'd255}, 1'b0, '0},
      // homing start clears alarm, direction and count
      '{'{REQ_HOME,    8'd85,  8'd170, 8'd85},  1'b1, QUIET_HOMING},
      '{'{REQ_BREATHE, 8'd0,   8'd0,   8'd0},   1'b1, QUIET_BREATHING},
      // minimum pots: longest period at defaults
      '{'{REQ_STEP,    8'd1,   8'd1,   8'd0},   1'b0, '0},
      '{'{REQ_STEP,    8'd255, 8'd255, 8'd0},   1'b0, '0},
      '{'{REQ_STEP,    8'd170, 8'd85,  8'd170}, 1'b0, '0},
      '{'{REQ_BREATHE, 8'd85,  8'd170, 8'd85},  1'b0, '0},
      '{'{REQ_UNUSED,  8'd170, 8'd85,  8'd170}, 1'b0, '0},
      '{'{REQ_STEP,    8'd85,  8'd170, 8'd85},  1'b0, '0}
   };

   // ------------------------------------------------------------------------
   // DUT ports
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [REQ_W-1:0]      req_type = '0;
   logic [SMP_W-1:0]      req_volume_pot = '0;
   logic [SMP_W-1:0]      req_rate_pot = '0;
   logic [SMP_W-1:0]      req_bellows_pressure = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_update_valid;
   logic                  rsp_direction_up;
   logic [PERIOD_W-1:0]   rsp_step_period;
   logic [PERIOD_W-1:0]   rsp_step_compare;
   logic [PAUSE_W-1:0]    rsp_pause_ms;
   logic                  rsp_motor_enable;
   logic                  rsp_pressure_alarm;
   logic [MODE_W-1:0]     rsp_mode;

   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bellows_stroke_sequencer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_volume_pot      (req_volume_pot),
      .req_rate_pot        (req_rate_pot),
      .req_bellows_pressure(req_bellows_pressure),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_update_valid    (rsp_update_valid),
      .rsp_direction_up    (rsp_direction_up),
      .rsp_step_period     (rsp_step_period),
      .rsp_step_compare    (rsp_step_compare),
      .rsp_pause_ms        (rsp_pause_ms),
      .rsp_motor_enable    (rsp_motor_enable),
      .rsp_pressure_alarm  (rsp_pressure_alarm),
      .rsp_mode            (rsp_mode),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a copy of the sequencer registers and its settings
   // ------------------------------------------------------------------------
   logic [HOME_W-1:0]  cfg_home_steps = HOME_STEPS_RST;
   logic [GEAR_W-1:0]  cfg_gear = GEAR_FACTOR_RST;
   logic [RMAX_W-1:0]  cfg_rate_max = RATE_MAX_RST;
   logic [LIMIT_W-1:0] cfg_limit = PRESSURE_LIMIT_RST;
   logic [PAUSE_W-1:0] cfg_up_pause = UP_PAUSE_RST;
   logic [PAUSE_W-1:0] cfg_down_pause = DOWN_PAUSE_RST;

   mode_type           run_mode = MODE_IDLE;
   logic [COUNT_W-1:0] stroke_count = '0;
   logic [COUNT_W-1:0] stroke_target = '0;
   logic               next_up = 1'b0;
   logic               motor_on = 1'b0;
   logic               alarm_flag = 1'b0;
   logic [31:0]        last_period = '0;

   stroke_update_type expected_updates [$];

   int mismatches = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int effective_sent = 0;   // unused request codes left out
   int burst_left = 0;
   int stall_left = 0;
   int stall_style = 0;
   int stroke_ends = 0;
   int zero_divisors = 0;
   int saturations = 0;
   int homings_done = 0;
   int alarm_pulses = 0;

   // Stroke length from volume: vol * ((total - half) >> SAMPLE_BITS),
   // zero base when the gear leaves total under half a revolution.
   function automatic logic [COUNT_W-1:0] volume_target(input logic [SMP_W-1:0] vol);
      int unsigned total;
      int unsigned half;
      int unsigned base;
      total = 32'(cfg_home_steps) * 32'(cfg_gear);
      half = 32'(cfg_home_steps) >> 1;
      base = (total >= half) ? ((total - half) >> SAMPLE_BITS) : 0;
      return COUNT_W'(32'(vol) * base);
   endfunction

   // Step timer reload: clock * 60 << 2*SAMPLE_BITS over the divisor product,
   // minus one, with floor and saturation.
   function automatic logic [31:0] stroke_period(input logic [SMP_W-1:0] vol,
                                                 input logic [SMP_W-1:0] rate);
      longint unsigned num;
      longint unsigned den;
      longint unsigned quot;
      num = TICKS_PER_SEC * (SEC_PER_MINUTE << (2 * SAMPLE_BITS));
      den = 64'(vol) * 64'(cfg_home_steps) * 64'(cfg_gear) * 64'(rate)
            * 64'(cfg_rate_max);
      if (den == 0) begin
         zero_divisors++;
         return PERIOD_SAT;
      end
      quot = num / den;
      if (quot <= 1) begin
         return PERIOD_FLOOR;
      end
      quot = quot - 1;
      if (quot > 64'h0000_0000_FFFF_FFFF) begin
         saturations++;
         return PERIOD_SAT;
      end
      return quot[31:0];
   endfunction

   // Advances the predicted state by one accepted request, returns its result
   function automatic stroke_update_type predict_stroke(input bellows_req_type item);
      stroke_update_type r;
      r = '0;
      case (item.kind)
         REQ_HOME: begin
            stroke_count = '0;
            stroke_target = '0;
            next_up = 1'b0;
            alarm_flag = 1'b0;
            run_mode = MODE_HOME;
            motor_on = 1'b1;
         end
         REQ_BREATHE: begin
            // count is kept, so a long count can end a stroke at once
            stroke_target = volume_target(item.volume);
            run_mode = MODE_BREATHE;
            motor_on = 1'b1;
         end
         REQ_STEP: begin
            if (run_mode == MODE_HOME) begin
               next_up = 1'b0;
               stroke_target = COUNT_W'(cfg_home_steps);
               if (stroke_count >= stroke_target) begin
                  stroke_count = '0;
                  run_mode = MODE_IDLE;
                  motor_on = 1'b0;
                  homings_done++;
               end else begin
                  stroke_count = stroke_count + 1'b1;
               end
            end else if (run_mode == MODE_BREATHE) begin
               alarm_flag = (item.pressure > cfg_limit);
               if (alarm_flag) alarm_pulses++;
               if (stroke_count >= stroke_target) begin
                  last_period = stroke_period(item.volume, item.rate);
                  r.update = 1'b1;
                  stroke_ends++;
                  if (next_up) begin
                     // up stroke ends: full period, new target
                     next_up = 1'b0;
                     stroke_target = volume_target(item.volume);
                     r.period = last_period;
                     r.compare = last_period >> 1;
                     r.pause = cfg_up_pause;
                  end else begin
                     // down stroke ends: half period
                     next_up = 1'b1;
                     r.period = last_period >> 1;
                     r.compare = last_period >> 2;
                     r.pause = cfg_down_pause;
                  end
                  stroke_count = '0;
               end else begin
                  stroke_count = stroke_count + 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.dir_up = !next_up;
      r.motor = motor_on;
      r.alarm = alarm_flag;
      r.mode = run_mode;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Volume mostly tiny so strokes stay short; rate mostly full range.
   function automatic bellows_req_type random_req(input logic [REQ_W-1:0] kind);
      bellows_req_type r;
      r.kind = kind;
      r.volume = ($urandom_range(0, 3) == 0) ? SMP_W'($urandom) : SMP_W'($urandom_range(0, 3));
      r.rate = ($urandom_range(0, 4) == 0) ? SMP_W'($urandom_range(0, 3)) : SMP_W'($urandom);
      r.pressure = SMP_W'($urandom);
      return r;
   endfunction

   // Mostly step pulses, a few unused codes and stray session breaks
   function automatic bellows_req_type pulse_or_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 93) return random_req(REQ_STEP);
      if (roll < 96) return random_req(REQ_UNUSED);
      return random_req(REQ_W'($urandom_range(0, 3)));
   endfunction

   // One transfer on the request channel. The sender runs in bursts; before a
   // burst, valid drops for a random gap. The prediction is made at the
   // transfer, so expectations queue up in acceptance order.
   task automatic send_request(input bellows_req_type item, input logic typed,
                               input stroke_update_type typed_want);
      stroke_update_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= item.kind;
      req_volume_pot <= item.volume;
      req_rate_pot <= item.rate;
      req_bellows_pressure <= item.pressure;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_stroke(item);
      expected_updates.push_back(typed ? typed_want : predicted);
      requests_sent++;
      if (item.kind != REQ_UNUSED) effective_sent++;
   endtask

   // Mostly a homing start and pulses (often enough to finish on a short distance),
   // then a breathing start and a run of breathing pulses.
   task automatic run_session();
      int n;
      if ($urandom_range(0, 4) != 0) begin
         send_request(random_req(REQ_HOME), 1'b0, '0);
         if (cfg_home_steps < 48 && $urandom_range(0, 3) != 0) begin
            n = int'(cfg_home_steps) + 1 + $urandom_range(0, 3);
         end else begin
            n = $urandom_range(1, 40);
         end
         repeat (n) send_request(pulse_or_noise(), 1'b0, '0);
      end
      send_request(random_req(REQ_BREATHE), 1'b0, '0);
      n = $urandom_range(4, 60);
      repeat (n) send_request(pulse_or_noise(), 1'b0, '0);
   endtask

   // Every result in, then the block is left to settle before the next phase
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_setting_type s);
      write_reg(CSR_HOME_STEPS, CSR_DATA_W'(s.home));
      write_reg(CSR_GEAR_FACTOR, CSR_DATA_W'(s.gear));
      write_reg(CSR_RATE_MAX, CSR_DATA_W'(s.rmax));
      write_reg(CSR_PRESSURE_LIMIT, CSR_DATA_W'(s.limit));
      write_reg(CSR_UP_PAUSE, s.up_pause);
      write_reg(CSR_DOWN_PAUSE, s.down_pause);
      csr_write_en <= 1'b0;
      cfg_home_steps = s.home;
      cfg_gear = s.gear;
      cfg_rate_max = s.rmax;
      cfg_limit = s.limit;
      cfg_up_pause = s.up_pause;
      cfg_down_pause = s.down_pause;
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Stall pattern: clear stretches, choppy stretches, held stalls
   always @(posedge clock) begin : sink_stall
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_left = (stall_style == 2) ? $urandom_range(1, 24) : $urandom_range(4, 60);
      end
      stall_left--;
      rsp_stall <= (stall_style == 2) || (stall_style == 1 && $urandom_range(0, 1) == 1);
   end

   // Each transfer on the result channel is held against the oldest expectation
   always @(posedge clock) begin : response_check
      stroke_update_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_updates.size() == 0) begin
            mismatches++;
            $display("%0t ns: result with no request pending", $time);
         end else begin
            want = expected_updates.pop_front();
            results_checked++;
            check_field("update_valid", want.update, rsp_update_valid);
            check_field("direction_up", want.dir_up, rsp_direction_up);
            check_field("step_period", want.period, rsp_step_period);
            check_field("step_compare", want.compare, rsp_step_compare);
            check_field("pause_ms", want.pause, rsp_pause_ms);
            check_field("motor_enable", want.motor, rsp_motor_enable);
            check_field("pressure_alarm", want.alarm, rsp_pressure_alarm);
            check_field("mode", want.mode, rsp_mode);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      cfg_setting_type settings [NUM_SETTINGS];
      int base_count;

      // near-bottom and top values of every register, a small mid point, then
      // random settings, all but the last with short homing distances
      settings[0] = '{12'd1, 4'd1, 8'd1, 8'd0, 16'd0, 16'd0};
      settings[1] = '{12'd4095, 4'd15, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF};
      settings[2] = '{12'd12, 4'd3, 8'd60, 8'd128, 16'd1000, 16'd500};
      for (int p = 3; p < NUM_SETTINGS; p++) begin
         settings[p].home = (p == NUM_SETTINGS - 1) ? HOME_W'($urandom_range(100, 300))
                                                    : HOME_W'($urandom_range(1, 60));
         settings[p].gear = GEAR_W'($urandom_range(1, 15));
         settings[p].rmax = RMAX_W'($urandom_range(1, 255));
         settings[p].limit = LIMIT_W'($urandom);
         settings[p].up_pause = PAUSE_W'($urandom);
         settings[p].down_pause = PAUSE_W'($urandom);
      end

      // hold reset, then release
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset defaults
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
      end
      wait_drain();

      // random sessions, one batch per register setting
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         apply_setting(settings[p]);
         base_count = effective_sent;
         while (effective_sent - base_count < ITEMS_PER_SETTING) run_session();
         wait_drain();
      end

      $display("%0d requests over %0d register settings, %0d results checked",
               requests_sent, NUM_SETTINGS + 1, results_checked);
      $display("%0d stroke ends (%0d zero divisor, %0d saturated), %0d homings done, %0d alarms",
               stroke_ends, zero_divisors, saturations, homings_done, alarm_pulses);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("timeout with %0d results outstanding", expected_updates.size());
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/bss_pkg.sv
rtl/core/bss_div.sv
rtl/core/bellows_stroke_sequencer_unit.sv
tb/tb.sv
